FILE: src/lj_pkg.sv
`timescale 1ns / 1ps

package lj_pkg;

	// default accumulator depth
	localparam int ATOMS_DEF = 4096;

	// field widths
	localparam int IDX_W = 12;
	localparam int POS_W = 32;
	localparam int FRC_W = 48;
	localparam int BOX_W = 31;
	localparam int CUT_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_AW = 2;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_BOX_X = 2'd0;
	localparam logic [CFG_AW-1:0] REG_BOX_Y = 2'd1;
	localparam logic [CFG_AW-1:0] REG_BOX_Z = 2'd2;
	localparam logic [CFG_AW-1:0] REG_CUTOFF = 2'd3;

	// register reset values
	localparam logic [BOX_W-1:0] BOX_RST = 31'd4194304;
	localparam logic [CUT_W-1:0] CUT_RST = 32'd1048576;

	// opcodes
	localparam logic OP_ACC = 1'b0;
	localparam logic OP_READ = 1'b1;

	// shared divider shape: 69-bit dividend, 62-bit divisor
	localparam int DIV_NW = 69;
	localparam int DIV_DW = 62;

	// arithmetic constants
	localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FR12_LIM = 64'd768614336404564650;
	localparam logic [63:0] SIG2_K = 64'd1660206966633859645;
	localparam logic [61:0] TINY_RSQ = 62'd10995;
	localparam logic [63:0] FMAX64 = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic signed [FRC_W-1:0] FMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [FRC_W-1:0] FMIN = 48'sh8000_0000_0000;

	// effective configuration seen by the datapath
	typedef struct packed {
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] bz;
		logic [CUT_W-1:0] cut;
	} cfg_t;

	// command word from front to back
	typedef struct packed {
		logic op;
		logic [IDX_W-1:0] ai;
		logic [IDX_W-1:0] aj;
		logic signed [FRC_W-1:0] fx;
		logic signed [FRC_W-1:0] fy;
		logic signed [FRC_W-1:0] fz;
	} cmd_t;

endpackage

FILE: src/lennard_jones_pair_force_accumulator_core.sv
`timescale 1ns / 1ps

// Lennard-Jones 12-6 pair force accumulator with minimum-image wrapping.
// Input side is a queue write: a word is taken when push is high and full
// is low. Opcode 0 carries a neighbor pair and produces no result; opcode 1
// reads and clears one atom's force and produces one result word.
// Result side is a queue read: the word on atom_index/force_* is valid while
// empty is low and is taken when pop is high.
// Config registers (box_x/y/z, cutoff_sq) are written through cfg_we,
// cfg_addr, cfg_wdata with no wait; write only while the block is idle.
// Front end: a pair uses the shared one-bit-per-cycle divider for three
// wraps and, inside the cutoff window, two reciprocals, then seven 64x64
// products on one 32x32 multiplier, and takes no new word until done. A
// read goes through the front end's emit state to the command queue; the
// back end registers the result in its read state, and for a pair does
// a read and write of atom i, then of atom j. After reset the accumulators
// are cleared one entry per cycle; full stays high until that is done. If
// the receiver stalls, one result is held, further reads wait in a 2-entry
// command queue, and full stays high while the front end waits on it.
module lennard_jones_pair_force_accumulator_core
	import lj_pkg::*;
#(
	parameter int ATOMS = ATOMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_AW-1:0] cfg_addr,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic push,
	output logic full,
	input logic opcode,
	input logic [IDX_W-1:0] atom_i,
	input logic [IDX_W-1:0] atom_j,
	input logic signed [POS_W-1:0] pos_i_x,
	input logic signed [POS_W-1:0] pos_i_y,
	input logic signed [POS_W-1:0] pos_i_z,
	input logic signed [POS_W-1:0] pos_j_x,
	input logic signed [POS_W-1:0] pos_j_y,
	input logic signed [POS_W-1:0] pos_j_z,
	output logic empty,
	input logic pop,
	output logic [IDX_W-1:0] atom_index,
	output logic signed [FRC_W-1:0] force_x,
	output logic signed [FRC_W-1:0] force_y,
	output logic signed [FRC_W-1:0] force_z
);

	logic [BOX_W-1:0] box_x_q, box_y_q, box_z_q;
	logic [CUT_W-1:0] cutoff_q;
	cfg_t cfg;
	logic clr_busy;
	logic cq_push, cq_full;
	cmd_t cq_cmd;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BOX_RST;
			box_y_q <= BOX_RST;
			box_z_q <= BOX_RST;
			cutoff_q <= CUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BOX_X: box_x_q <= cfg_wdata[BOX_W-1:0];
				REG_BOX_Y: box_y_q <= cfg_wdata[BOX_W-1:0];
				REG_BOX_Z: box_z_q <= cfg_wdata[BOX_W-1:0];
				REG_CUTOFF: cutoff_q <= cfg_wdata[CUT_W-1:0];
				default: cutoff_q <= cutoff_q;
			endcase
		end
	end

	// a zero box length means 2^31
	always_comb begin
		cfg.bx = (box_x_q == '0) ? 32'h8000_0000 : {1'b0, box_x_q};
		cfg.by = (box_y_q == '0) ? 32'h8000_0000 : {1'b0, box_y_q};
		cfg.bz = (box_z_q == '0) ? 32'h8000_0000 : {1'b0, box_z_q};
		cfg.cut = cutoff_q;
	end

	lj_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.hold(clr_busy),
		.push(push),
		.full(full),
		.opcode(opcode),
		.atom_i(atom_i),
		.atom_j(atom_j),
		.pos_i_x(pos_i_x),
		.pos_i_y(pos_i_y),
		.pos_i_z(pos_i_z),
		.pos_j_x(pos_j_x),
		.pos_j_y(pos_j_y),
		.pos_j_z(pos_j_z),
		.cq_push(cq_push),
		.cq_full(cq_full),
		.cq_cmd(cq_cmd)
	);

	lj_back #(.ATOMS(ATOMS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cq_push(cq_push),
		.cq_full(cq_full),
		.cq_cmd(cq_cmd),
		.clr_busy(clr_busy),
		.empty(empty),
		.pop(pop),
		.atom_index(atom_index),
		.force_x(force_x),
		.force_y(force_y),
		.force_z(force_z)
	);

endmodule

FILE: src/lj_ram.sv
`timescale 1ns / 1ps

module lj_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, read before write, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: src/lj_div.sv
`timescale 1ns / 1ps

module lj_div
	import lj_pkg::*;
#(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0] trial;
	logic [DW:0] rem_n;
	logic take;

	// restoring step: one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		take = trial >= {1'b0, den_q};
		rem_n = take ? trial - {1'b0, den_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= rem_n[DW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo = quo_q;
	assign rem = rem_q;

endmodule

FILE: src/lj_front.sv
`timescale 1ns / 1ps

module lj_front
	import lj_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic hold,
	input logic push,
	output logic full,
	input logic opcode,
	input logic [IDX_W-1:0] atom_i,
	input logic [IDX_W-1:0] atom_j,
	input logic signed [POS_W-1:0] pos_i_x,
	input logic signed [POS_W-1:0] pos_i_y,
	input logic signed [POS_W-1:0] pos_i_z,
	input logic signed [POS_W-1:0] pos_j_x,
	input logic signed [POS_W-1:0] pos_j_y,
	input logic signed [POS_W-1:0] pos_j_z,
	output logic cq_push,
	input logic cq_full,
	output cmd_t cq_cmd
);

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_DIV = 4'd1;
	localparam logic [3:0] F_DIVW = 4'd2;
	localparam logic [3:0] F_SQ = 4'd3;
	localparam logic [3:0] F_SQA = 4'd4;
	localparam logic [3:0] F_CHK = 4'd5;
	localparam logic [3:0] F_S2W = 4'd6;
	localparam logic [3:0] F_INVW = 4'd7;
	localparam logic [3:0] F_MUL = 4'd8;
	localparam logic [3:0] F_MULD = 4'd9;
	localparam logic [3:0] F_EMIT = 4'd10;

	// multiply step codes
	localparam logic [2:0] M_S4 = 3'd0;
	localparam logic [2:0] M_S6 = 3'd1;
	localparam logic [2:0] M_S12 = 3'd2;
	localparam logic [2:0] M_FR = 3'd3;
	localparam logic [2:0] M_FX = 3'd4;
	localparam logic [2:0] M_FY = 3'd5;
	localparam logic [2:0] M_FZ = 3'd6;

	logic [3:0] state_q;
	logic op_q;
	logic [IDX_W-1:0] ai_q, aj_q;
	logic [POS_W:0] d_q [3];
	logic [1:0] ax_q;
	logic [30:0] u_q [3];
	logic [2:0] sg_q;
	logic [61:0] rsq_q;
	logic [63:0] s2_q, inv_q, s6_q, fr_q, ma_q, mb_q, pp_q;
	logic [127:0] acc_q;
	logic [2:0] mc_q;
	logic [1:0] pk_q;
	logic [2:0] mop_q;
	logic frneg_q;
	logic signed [FRC_W-1:0] fx_q, fy_q, fz_q;

	logic div_start, div_busy;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den, div_rem;

	logic [POS_W:0] cur_d, dmag;
	logic neg;
	logic [31:0] bx_sel, r, wmag;
	logic inc;
	logic valid;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [127:0] acc_add, shifted;
	logic [63:0] res, a2, diff, fr12;
	logic fr_neg_n;
	logic [46:0] cm;
	logic cneg;
	logic signed [FRC_W-1:0] comp;

	lj_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.quo(div_quo),
		.rem(div_rem)
	);

	// minimum image: current axis magnitude and round-half-even wrap
	always_comb begin
		cur_d = d_q[ax_q];
		neg = cur_d[POS_W];
		dmag = neg ? (~cur_d + 1'b1) : cur_d;
		case (ax_q)
			2'd0: bx_sel = cfg.bx;
			2'd1: bx_sel = cfg.by;
			default: bx_sel = cfg.bz;
		endcase
		r = div_rem[31:0];
		inc = ({r, 1'b0} > {1'b0, bx_sel}) ||
			(({r, 1'b0} == {1'b0, bx_sel}) && div_quo[0]);
		wmag = inc ? bx_sel - r : r;
	end

	// pair window: above the tiny bound, below the cutoff
	assign valid = (rsq_q > TINY_RSQ) && (rsq_q < 62'({cfg.cut, 20'b0}));

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		case (state_q)
			F_DIV: begin
				div_start = 1'b1;
				div_num = DIV_NW'(dmag);
				div_den = DIV_DW'(bx_sel);
			end
			F_CHK: begin
				div_start = valid;
				div_num = {SIG2_K[60:0], 8'b0};
				div_den = rsq_q;
			end
			F_S2W: begin
				div_start = !div_busy;
				div_num = {8'b0, 1'b1, 60'b0};
				div_den = rsq_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// shared 32x32 multiplier: squares, or one partial product of a 64x64
	always_comb begin
		if (state_q == F_SQ) begin
			mul_a = {1'b0, u_q[ax_q]};
			mul_b = {1'b0, u_q[ax_q]};
		end else begin
			mul_a = mc_q[1] ? ma_q[63:32] : ma_q[31:0];
			mul_b = mc_q[0] ? mb_q[63:32] : mb_q[31:0];
		end
		mul_p = mul_a * mul_b;
		acc_add = 128'(pp_q) << {pk_q, 5'b0};
	end

	// scale and saturate the finished product, then per-step post ops
	always_comb begin
		case (mop_q)
			M_FR: shifted = acc_q >> 36;
			M_FX, M_FY, M_FZ: shifted = acc_q >> 20;
			default: shifted = acc_q >> 32;
		endcase
		res = (|shifted[127:63]) ? SAT63 : {1'b0, shifted[62:0]};
		a2 = res[62] ? SAT63 : {res[62:0], 1'b0};
		fr_neg_n = a2 < s6_q;
		diff = fr_neg_n ? s6_q - a2 : a2 - s6_q;
		fr12 = (res > FR12_LIM) ? SAT63 : (res << 3) + (res << 2);
		cm = (res > FMAX64) ? FMAX64[46:0] : res[46:0];
		case (mop_q)
			M_FX: cneg = frneg_q != sg_q[0];
			M_FY: cneg = frneg_q != sg_q[1];
			default: cneg = frneg_q != sg_q[2];
		endcase
		comp = cneg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			op_q <= OP_ACC;
			ai_q <= '0;
			aj_q <= '0;
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= '0;
				u_q[k] <= '0;
			end
			sg_q <= '0;
			ax_q <= '0;
			rsq_q <= '0;
			s2_q <= '0;
			inv_q <= '0;
			s6_q <= '0;
			fr_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			pp_q <= '0;
			acc_q <= '0;
			mc_q <= '0;
			pk_q <= '0;
			mop_q <= M_S4;
			frneg_q <= 1'b0;
			fx_q <= '0;
			fy_q <= '0;
			fz_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push && !full) begin
						op_q <= opcode;
						ai_q <= atom_i;
						aj_q <= atom_j;
						d_q[0] <= {pos_i_x[POS_W-1], pos_i_x} - {pos_j_x[POS_W-1], pos_j_x};
						d_q[1] <= {pos_i_y[POS_W-1], pos_i_y} - {pos_j_y[POS_W-1], pos_j_y};
						d_q[2] <= {pos_i_z[POS_W-1], pos_i_z} - {pos_j_z[POS_W-1], pos_j_z};
						ax_q <= '0;
						state_q <= (opcode == OP_READ) ? F_EMIT : F_DIV;
					end
				end
				F_DIV: begin
					state_q <= F_DIVW;
				end
				F_DIVW: begin
					if (!div_busy) begin
						u_q[ax_q] <= wmag[30:0];
						sg_q[ax_q] <= neg ^ inc;
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							rsq_q <= '0;
							state_q <= F_SQ;
						end else begin
							ax_q <= ax_q + 1'b1;
							state_q <= F_DIV;
						end
					end
				end
				F_SQ: begin
					pp_q <= mul_p;
					state_q <= F_SQA;
				end
				F_SQA: begin
					rsq_q <= rsq_q + pp_q[61:0];
					if (ax_q == 2'd2) begin
						state_q <= F_CHK;
					end else begin
						ax_q <= ax_q + 1'b1;
						state_q <= F_SQ;
					end
				end
				F_CHK: begin
					state_q <= valid ? F_S2W : F_IDLE;
				end
				F_S2W: begin
					if (!div_busy) begin
						s2_q <= div_quo[63:0];
						state_q <= F_INVW;
					end
				end
				F_INVW: begin
					if (!div_busy) begin
						inv_q <= div_quo[63:0];
						ma_q <= s2_q;
						mb_q <= s2_q;
						mop_q <= M_S4;
						acc_q <= '0;
						mc_q <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					// partial product k registered, added in the next cycle
					if (mc_q != 3'd4) begin
						pp_q <= mul_p;
						pk_q <= 2'(mc_q[1]) + 2'(mc_q[0]);
					end
					if (mc_q != 3'd0) begin
						acc_q <= acc_q + acc_add;
					end
					mc_q <= mc_q + 1'b1;
					if (mc_q == 3'd4) begin
						state_q <= F_MULD;
					end
				end
				F_MULD: begin
					acc_q <= '0;
					mc_q <= '0;
					state_q <= F_MUL;
					case (mop_q)
						M_S4: begin
							ma_q <= res;
							mb_q <= s2_q;
							mop_q <= M_S6;
						end
						M_S6: begin
							s6_q <= res;
							ma_q <= res;
							mb_q <= res;
							mop_q <= M_S12;
						end
						M_S12: begin
							frneg_q <= fr_neg_n;
							ma_q <= diff;
							mb_q <= inv_q;
							mop_q <= M_FR;
						end
						M_FR: begin
							fr_q <= fr12;
							ma_q <= fr12;
							mb_q <= 64'(u_q[0]);
							mop_q <= M_FX;
						end
						M_FX: begin
							fx_q <= comp;
							ma_q <= fr_q;
							mb_q <= 64'(u_q[1]);
							mop_q <= M_FY;
						end
						M_FY: begin
							fy_q <= comp;
							ma_q <= fr_q;
							mb_q <= 64'(u_q[2]);
							mop_q <= M_FZ;
						end
						M_FZ: begin
							fz_q <= comp;
							state_q <= F_EMIT;
						end
						default: begin
							state_q <= F_IDLE;
						end
					endcase
				end
				F_EMIT: begin
					if (!cq_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign full = (state_q != F_IDLE) || hold;
	assign cq_push = (state_q == F_EMIT) && !cq_full;

	always_comb begin
		cq_cmd.op = op_q;
		cq_cmd.ai = ai_q;
		cq_cmd.aj = aj_q;
		cq_cmd.fx = fx_q;
		cq_cmd.fy = fy_q;
		cq_cmd.fz = fz_q;
	end

endmodule

FILE: src/lj_back.sv
`timescale 1ns / 1ps

module lj_back
	import lj_pkg::*;
#(
	parameter int ATOMS = ATOMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cq_push,
	output logic cq_full,
	input cmd_t cq_cmd,
	output logic clr_busy,
	output logic empty,
	input logic pop,
	output logic [IDX_W-1:0] atom_index,
	output logic signed [FRC_W-1:0] force_x,
	output logic signed [FRC_W-1:0] force_y,
	output logic signed [FRC_W-1:0] force_z
);

	localparam int AW = $clog2(ATOMS);

	localparam logic [2:0] B_CLR = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_RD = 3'd2;
	localparam logic [2:0] B_AI = 3'd3;
	localparam logic [2:0] B_J = 3'd4;
	localparam logic [2:0] B_AJ = 3'd5;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	cmd_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t head, cur_q;
	logic deq;
	logic oval_q;
	logic [IDX_W-1:0] oidx_q;
	logic signed [FRC_W-1:0] ofx_q, ofy_q, ofz_q;

	logic [AW-1:0] ram_addr;
	logic ram_we;
	logic [FRC_W-1:0] wx, wy, wz, rx, ry, rz;

	function automatic logic in_rng(input logic [IDX_W-1:0] idx);
		return 32'(idx) < ATOMS;
	endfunction

	function automatic logic [FRC_W-1:0] sat_add(input logic signed [FRC_W-1:0] a,
		input logic signed [FRC_W-1:0] b);
		logic signed [FRC_W:0] s;
		s = {a[FRC_W-1], a} + {b[FRC_W-1], b};
		if (s > $signed({FMAX[FRC_W-1], FMAX})) begin
			return FMAX;
		end else if (s < $signed({FMIN[FRC_W-1], FMIN})) begin
			return FMIN;
		end
		return s[FRC_W-1:0];
	endfunction

	lj_ram #(.WIDTH(FRC_W), .DEPTH(ATOMS)) u_ram_x (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wx), .rdata(rx)
	);
	lj_ram #(.WIDTH(FRC_W), .DEPTH(ATOMS)) u_ram_y (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wy), .rdata(ry)
	);
	lj_ram #(.WIDTH(FRC_W), .DEPTH(ATOMS)) u_ram_z (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wz), .rdata(rz)
	);

	// command queue head; reads only go ahead when the result slot is free
	assign head = q_q[rp_q];
	assign cq_full = cnt_q == 2'd2;
	assign deq = (state_q == B_IDLE) && (cnt_q != 2'd0) &&
		((head.op == OP_ACC) || !oval_q);

	// accumulator port control
	always_comb begin
		ram_addr = AW'(cur_q.ai);
		ram_we = 1'b0;
		wx = '0;
		wy = '0;
		wz = '0;
		case (state_q)
			B_CLR: begin
				ram_addr = clr_q;
				ram_we = 1'b1;
			end
			B_IDLE: begin
				ram_addr = AW'(head.ai);
			end
			B_RD: begin
				ram_we = 1'b1;
			end
			B_AI: begin
				ram_we = 1'b1;
				wx = sat_add(rx, cur_q.fx);
				wy = sat_add(ry, cur_q.fy);
				wz = sat_add(rz, cur_q.fz);
			end
			B_J: begin
				ram_addr = AW'(cur_q.aj);
			end
			B_AJ: begin
				ram_addr = AW'(cur_q.aj);
				ram_we = 1'b1;
				wx = sat_add(rx, -cur_q.fx);
				wy = sat_add(ry, -cur_q.fy);
				wz = sat_add(rz, -cur_q.fz);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q <= '0;
			q_q[0] <= '0;
			q_q[1] <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
			cur_q <= '0;
			oval_q <= 1'b0;
			oidx_q <= '0;
			ofx_q <= '0;
			ofy_q <= '0;
			ofz_q <= '0;
		end else begin
			// queue bookkeeping
			if (cq_push) begin
				q_q[wp_q] <= cq_cmd;
				wp_q <= ~wp_q;
			end
			if (deq) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(cq_push) - 2'(deq);

			if (pop && oval_q) begin
				oval_q <= 1'b0;
			end

			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ATOMS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (deq) begin
						cur_q <= head;
						if (head.op == OP_READ) begin
							if (in_rng(head.ai)) begin
								state_q <= B_RD;
							end else begin
								oval_q <= 1'b1;
								oidx_q <= head.ai;
								ofx_q <= '0;
								ofy_q <= '0;
								ofz_q <= '0;
							end
						end else begin
							state_q <= in_rng(head.ai) ? B_AI : B_J;
						end
					end
				end
				B_RD: begin
					oval_q <= 1'b1;
					oidx_q <= cur_q.ai;
					ofx_q <= rx;
					ofy_q <= ry;
					ofz_q <= rz;
					state_q <= B_IDLE;
				end
				B_AI: begin
					state_q <= B_J;
				end
				B_J: begin
					state_q <= in_rng(cur_q.aj) ? B_AJ : B_IDLE;
				end
				B_AJ: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign clr_busy = state_q == B_CLR;
	assign empty = !oval_q;
	assign atom_index = oidx_q;
	assign force_x = ofx_q;
	assign force_y = ofy_q;
	assign force_z = ofz_q;

endmodule
